### hw/rtl/mspc_pkg.sv
// ----------------------------------------------------------------------------
// mspc_pkg
// Shared constants, types and codes of the multiplexed servo pulse controller.
// ----------------------------------------------------------------------------
package mspc_pkg;

  // sizing
  localparam int NUM_SERVOS        = 32;
  localparam int SLOTS_PER_CHANNEL = 8;
  localparam int NUM_CHANNELS      = 3;
  localparam int CH_HW             = 4;
  localparam int IDX_W             = $clog2(NUM_SERVOS);
  localparam int SIDX_W            = $clog2(CH_HW * SLOTS_PER_CHANNEL + 1);

  // field widths
  localparam int BYTE_W     = 8;
  localparam int VAL_W      = 16;
  localparam int IVL_W      = 17;
  localparam int ADDR_LOW_W = 5;
  localparam int CH_W       = 2;
  localparam int SLOT_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 17;

  // constants
  localparam logic [IVL_W-1:0]      DEFAULT_POSITION = 17'd36100;
  localparam logic [BYTE_W-1:0]     SYNC_BYTE        = 8'd255;
  localparam logic [BYTE_W-1:0]     ENGAGE_ADDR      = 8'hFF;
  localparam logic [BYTE_W-1:0]     TABLE_LIMIT      = 8'd32;
  localparam logic [BYTE_W-1:0]     CACHE_LIMIT      = 8'd64;
  localparam logic [VAL_W-1:0]      MAX_CMD_RST      = 16'd62000;
  localparam logic [VAL_W-1:0]      OFFSET_RST       = 16'd12100;
  localparam logic [IVL_W-1:0]      SYNC_GAP_RST     = 17'd1000;
  localparam logic [ADDR_LOW_W-1:0] LAST_ADDR_RST    = 5'd23;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_COMMAND  = 2'd0,
    CFG_PULSE_OFFSET = 2'd1,
    CFG_SYNC_GAP     = 2'd2,
    CFG_LAST_ADDRESS = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    PH_SYNC  = 3'd0,
    PH_ADDR  = 3'd1,
    PH_HIGH  = 3'd2,
    PH_LOW   = 3'd3,
    PH_SKIP1 = 3'd4,
    PH_SKIP2 = 3'd5
  } parse_phase_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_DECODE = 3'd1,
    ST_READ   = 3'd2,
    ST_COPY   = 3'd3,
    ST_EMIT   = 3'd4
  } state_e;

  typedef enum logic [1:0] {
    ACT_MOVE   = 2'd0,
    ACT_CACHED = 2'd1,
    ACT_ENGAGE = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic {
    KIND_PACKET  = 1'b0,
    KIND_COMPARE = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [CH_W-1:0]    channel;
    logic [SLOT_W-1:0]  slot;
    logic [IVL_W-1:0]   interval;
    logic               reset_pulse;
    action_e            action;
  } result_t;

  typedef struct packed {
    logic latch_in;
    logic decode;
    logic read_done;
    logic copy_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_cmp;
    logic cmp_ok;
    logic slot_sync;
    logic pkt_done;
    logic engage;
    logic copy_last;
    logic out_free;
  } dp_status_t;

endpackage

### hw/rtl/multiplexed_servo_pulse_controller.sv
// ----------------------------------------------------------------------------
// multiplexed_servo_pulse_controller
// Serial command parser and pulse interval generator for chained servos.
// ----------------------------------------------------------------------------
// One request is handled at a time. A serial byte that completes no packet
// goes from decode straight back to idle, as does a compare on the
// unused channel. A completed move or cache packet passes decode and emit,
// and so does a compare that lands on the sync slot. A compare on a servo
// slot passes a read state between them, because the position table read is
// registered. An engage packet runs a copy sweep before emit, which copies
// the 32 cache entries through the cache's single read port. A finished
// result sits in an output register, so the next request is taken while it
// waits. Emit holds until that register is free. Both tables start at the
// default position through per-entry valid bits; no clearing pass.
module multiplexed_servo_pulse_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mspc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mspc_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           cmd_i,
  input  logic [mspc_pkg::BYTE_W-1:0]    rx_byte_i,
  input  logic [mspc_pkg::CH_W-1:0]      channel_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           result_kind_o,
  output logic [mspc_pkg::CH_W-1:0]      out_channel_o,
  output logic [mspc_pkg::SLOT_W-1:0]    slot_o,
  output logic [mspc_pkg::IVL_W-1:0]     interval_o,
  output logic                           reset_pulse_o,
  output logic [1:0]                     action_o
);

  mspc_pkg::ctrl_cmd_t  ctrl;
  mspc_pkg::dp_status_t status;
  mspc_pkg::result_t    out_res;

  mspc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  mspc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd_i),
    .rx_byte_i   (rx_byte_i),
    .channel_i   (channel_i),
    .out_ready_i (out_ready_i),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_o       (out_res)
  );

  assign result_kind_o = out_res.kind;
  assign out_channel_o = out_res.channel;
  assign slot_o        = out_res.slot;
  assign interval_o    = out_res.interval;
  assign reset_pulse_o = out_res.reset_pulse;
  assign action_o      = out_res.action;

endmodule

### hw/rtl/mspc_datapath.sv
// ----------------------------------------------------------------------------
// mspc_datapath
// Config registers, serial parser state, position table and staging cache,
// per-channel slot counters, result and output registers.
// ----------------------------------------------------------------------------
module mspc_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mspc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mspc_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                cmd_i,
  input  logic [mspc_pkg::BYTE_W-1:0]         rx_byte_i,
  input  logic [mspc_pkg::CH_W-1:0]           channel_i,
  input  logic                                out_ready_i,
  input  mspc_pkg::ctrl_cmd_t                 ctrl_i,
  output mspc_pkg::dp_status_t                status_o,
  output logic                                out_valid_o,
  output mspc_pkg::result_t                   out_o
);

  // configuration
  logic [mspc_pkg::VAL_W-1:0]      max_cmd_q;
  logic [mspc_pkg::VAL_W-1:0]      offset_q;
  logic [mspc_pkg::IVL_W-1:0]      sync_gap_q;
  logic [mspc_pkg::ADDR_LOW_W-1:0] last_addr_q;

  // latched request
  logic                            in_cmd_q;
  logic [mspc_pkg::BYTE_W-1:0]     in_byte_q;
  logic [mspc_pkg::CH_W-1:0]       in_ch_q;

  // parser
  mspc_pkg::parse_phase_e          phase_q, phase_d;
  logic [mspc_pkg::BYTE_W-1:0]     held_addr_q;
  logic [mspc_pkg::BYTE_W-1:0]     held_hi_q;

  // memories
  logic [mspc_pkg::IVL_W-1:0]      pos_mem   [mspc_pkg::NUM_SERVOS];
  logic [mspc_pkg::IVL_W-1:0]      cache_mem [mspc_pkg::NUM_SERVOS];
  logic [mspc_pkg::NUM_SERVOS-1:0] pos_vld_q;
  logic [mspc_pkg::NUM_SERVOS-1:0] cache_vld_q;
  logic [mspc_pkg::IVL_W-1:0]      pos_rd_q;
  logic                            pos_rd_vld_q;
  logic                            rd_in_range_q;
  logic [mspc_pkg::IVL_W-1:0]      cache_rd_q;
  logic                            cache_rd_vld_q;

  // engage copy sweep
  logic [mspc_pkg::IDX_W-1:0]      copy_cnt_q;
  logic                            copy_wr_q;
  logic [mspc_pkg::IDX_W-1:0]      copy_wa_q;

  // slot counters, one per hardware channel
  logic [mspc_pkg::SLOT_W-1:0]     slot_cnt_q [mspc_pkg::CH_HW];

  mspc_pkg::result_t               res_q;
  mspc_pkg::result_t               out_q;
  logic                            out_vld_q;

  // combinational
  logic                            addr_ok;
  logic [mspc_pkg::VAL_W-1:0]      value;
  logic [mspc_pkg::VAL_W-1:0]      clamped;
  logic [mspc_pkg::IVL_W-1:0]      stored;
  logic [mspc_pkg::ADDR_LOW_W-1:0] tbl_idx5;
  logic                            tbl_in_range;
  logic [mspc_pkg::IDX_W-1:0]      tbl_mem_idx;
  logic                            is_tbl;
  logic                            is_cache;
  logic                            is_engage;
  mspc_pkg::result_t               pkt_res;
  mspc_pkg::result_t               cmp_res;
  logic [mspc_pkg::SLOT_W-1:0]     cur_slot;
  logic                            slot_sync;
  logic [mspc_pkg::SIDX_W-1:0]     srv_idx;
  logic                            srv_in_range;
  logic [mspc_pkg::IDX_W-1:0]      srv_mem_idx;
  logic                            cmp_ok;
  logic                            dec_serial;
  logic                            dec_pkt;
  logic                            dec_cmp;
  logic                            pos_we;
  logic [mspc_pkg::IDX_W-1:0]      pos_wa;
  logic [mspc_pkg::IVL_W-1:0]      pos_wd;
  logic                            pos_wv;
  logic                            cache_we;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_cmd_q   <= mspc_pkg::MAX_CMD_RST;
      offset_q    <= mspc_pkg::OFFSET_RST;
      sync_gap_q  <= mspc_pkg::SYNC_GAP_RST;
      last_addr_q <= mspc_pkg::LAST_ADDR_RST;
    end else if (cfg_we_i) begin
      case (mspc_pkg::cfg_reg_e'(cfg_idx_i))
        mspc_pkg::CFG_MAX_COMMAND:  max_cmd_q   <= cfg_data_i[mspc_pkg::VAL_W-1:0];
        mspc_pkg::CFG_PULSE_OFFSET: offset_q    <= cfg_data_i[mspc_pkg::VAL_W-1:0];
        mspc_pkg::CFG_SYNC_GAP:     sync_gap_q  <= cfg_data_i[mspc_pkg::IVL_W-1:0];
        mspc_pkg::CFG_LAST_ADDRESS: last_addr_q <= cfg_data_i[mspc_pkg::ADDR_LOW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch_in) begin
      in_cmd_q  <= cmd_i;
      in_byte_q <= rx_byte_i;
      in_ch_q   <= channel_i;
    end
  end

  // packet arithmetic
  always_comb begin
    addr_ok      = (in_byte_q[mspc_pkg::ADDR_LOW_W-1:0] <= last_addr_q) ||
                   (in_byte_q == mspc_pkg::ENGAGE_ADDR);
    value        = {held_hi_q, in_byte_q};
    clamped      = (value > max_cmd_q) ? max_cmd_q : value;
    stored       = mspc_pkg::IVL_W'(clamped) + mspc_pkg::IVL_W'(offset_q);
    tbl_idx5     = held_addr_q[mspc_pkg::ADDR_LOW_W-1:0];
    tbl_in_range = 32'(tbl_idx5) < mspc_pkg::NUM_SERVOS;
    tbl_mem_idx  = mspc_pkg::IDX_W'(tbl_idx5);
    is_tbl       = held_addr_q < mspc_pkg::TABLE_LIMIT;
    is_cache     = !is_tbl && (held_addr_q < mspc_pkg::CACHE_LIMIT);
    is_engage    = held_addr_q == mspc_pkg::ENGAGE_ADDR;

    pkt_res             = '0;
    pkt_res.kind        = mspc_pkg::KIND_PACKET;
    pkt_res.action      = mspc_pkg::ACT_NONE;
    if ((is_tbl || is_cache) && tbl_in_range) begin
      pkt_res.interval = stored;
      pkt_res.action   = is_tbl ? mspc_pkg::ACT_MOVE : mspc_pkg::ACT_CACHED;
    end else if (is_engage) begin
      pkt_res.action   = mspc_pkg::ACT_ENGAGE;
    end
  end

  // compare arithmetic
  always_comb begin
    cmp_ok       = 32'(in_ch_q) < mspc_pkg::NUM_CHANNELS;
    cur_slot     = slot_cnt_q[in_ch_q];
    slot_sync    = cur_slot >= mspc_pkg::SLOT_W'(mspc_pkg::SLOTS_PER_CHANNEL);
    srv_idx      = mspc_pkg::SIDX_W'(in_ch_q) *
                   mspc_pkg::SIDX_W'(mspc_pkg::SLOTS_PER_CHANNEL) +
                   mspc_pkg::SIDX_W'(cur_slot);
    srv_in_range = 32'(srv_idx) < mspc_pkg::NUM_SERVOS;
    srv_mem_idx  = mspc_pkg::IDX_W'(srv_idx);

    cmp_res             = '0;
    cmp_res.kind        = mspc_pkg::KIND_COMPARE;
    cmp_res.channel     = in_ch_q;
    cmp_res.action      = mspc_pkg::ACT_NONE;
    if (slot_sync) begin
      cmp_res.slot        = mspc_pkg::SLOT_W'(mspc_pkg::SLOTS_PER_CHANNEL);
      cmp_res.interval    = sync_gap_q;
      cmp_res.reset_pulse = 1'b1;
    end else begin
      cmp_res.slot        = cur_slot;
    end
  end

  always_comb begin
    dec_serial = ctrl_i.decode && !in_cmd_q;
    dec_pkt    = dec_serial && (phase_q == mspc_pkg::PH_LOW);
    dec_cmp    = ctrl_i.decode && in_cmd_q && cmp_ok;
    pos_we     = (dec_pkt && is_tbl && tbl_in_range) || copy_wr_q;
    pos_wa     = copy_wr_q ? copy_wa_q : tbl_mem_idx;
    pos_wd     = copy_wr_q ? cache_rd_q : stored;
    pos_wv     = copy_wr_q ? cache_rd_vld_q : 1'b1;
    cache_we   = dec_pkt && is_cache && tbl_in_range;
  end

  // parser next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      mspc_pkg::PH_SYNC:  if (in_byte_q == mspc_pkg::SYNC_BYTE) phase_d = mspc_pkg::PH_ADDR;
      mspc_pkg::PH_ADDR:  phase_d = addr_ok ? mspc_pkg::PH_HIGH : mspc_pkg::PH_SKIP1;
      mspc_pkg::PH_HIGH:  phase_d = mspc_pkg::PH_LOW;
      mspc_pkg::PH_LOW:   phase_d = mspc_pkg::PH_SYNC;
      mspc_pkg::PH_SKIP1: phase_d = mspc_pkg::PH_SKIP2;
      default:            phase_d = mspc_pkg::PH_SYNC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= mspc_pkg::PH_SYNC;
      held_addr_q <= '0;
      held_hi_q   <= '0;
    end else if (dec_serial) begin
      phase_q <= phase_d;
      if (phase_q == mspc_pkg::PH_ADDR) begin
        held_addr_q <= in_byte_q;
      end
      if (phase_q == mspc_pkg::PH_HIGH) begin
        held_hi_q <= in_byte_q;
      end
    end
  end

  // position table
  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[pos_wa] <= pos_wd;
    end
    if (dec_cmp) begin
      pos_rd_q <= pos_mem[srv_mem_idx];
    end
  end

  // staging cache
  always_ff @(posedge clk_i) begin
    if (cache_we) begin
      cache_mem[tbl_mem_idx] <= stored;
    end
    if (ctrl_i.copy_step) begin
      cache_rd_q <= cache_mem[copy_cnt_q];
    end
  end

  // entries that are not valid read as the default position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_vld_q      <= '0;
      cache_vld_q    <= '0;
      pos_rd_vld_q   <= 1'b0;
      rd_in_range_q  <= 1'b0;
      cache_rd_vld_q <= 1'b0;
      copy_cnt_q     <= '0;
      copy_wr_q      <= 1'b0;
      copy_wa_q      <= '0;
    end else begin
      if (pos_we) begin
        pos_vld_q[pos_wa] <= pos_wv;
      end
      if (cache_we) begin
        cache_vld_q[tbl_mem_idx] <= 1'b1;
      end
      if (dec_cmp) begin
        pos_rd_vld_q  <= pos_vld_q[srv_mem_idx];
        rd_in_range_q <= srv_in_range;
      end
      if (ctrl_i.decode) begin
        copy_cnt_q <= '0;
      end else if (ctrl_i.copy_step) begin
        copy_cnt_q     <= copy_cnt_q + 1'b1;
        cache_rd_vld_q <= cache_vld_q[copy_cnt_q];
      end
      copy_wr_q <= ctrl_i.copy_step;
      copy_wa_q <= copy_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mspc_pkg::CH_HW; i++) begin
        slot_cnt_q[i] <= '0;
      end
    end else if (dec_cmp) begin
      slot_cnt_q[in_ch_q] <= slot_sync ? '0 : cur_slot + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dec_pkt) begin
      res_q <= pkt_res;
    end else if (dec_cmp) begin
      res_q <= cmp_res;
    end else if (ctrl_i.read_done) begin
      res_q.interval <= !rd_in_range_q ? '0 :
                        (pos_rd_vld_q ? pos_rd_q : mspc_pkg::DEFAULT_POSITION);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      out_q <= res_q;
    end
  end

  always_comb begin
    status_o.is_cmp    = in_cmd_q;
    status_o.cmp_ok    = cmp_ok;
    status_o.slot_sync = slot_sync;
    status_o.pkt_done  = phase_q == mspc_pkg::PH_LOW;
    status_o.engage    = is_engage;
    status_o.copy_last = copy_cnt_q == mspc_pkg::IDX_W'(mspc_pkg::NUM_SERVOS - 1);
    status_o.out_free  = !out_vld_q || out_ready_i;
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  // slot counters never run past the sync slot
  for (genvar g = 0; g < mspc_pkg::CH_HW; g++) begin : g_slot_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      slot_cnt_q[g] <= mspc_pkg::SLOT_W'(mspc_pkg::SLOTS_PER_CHANNEL))
      else $error("slot counter past sync slot");
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.kind == mspc_pkg::KIND_PACKET &&
     (out_q.action == mspc_pkg::ACT_ENGAGE || out_q.action == mspc_pkg::ACT_NONE))
    |-> out_q.interval == '0)
    else $error("packet without write shows a nonzero value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.kind == mspc_pkg::KIND_COMPARE)
    |-> (out_q.action == mspc_pkg::ACT_NONE) &&
        (out_q.reset_pulse ==
         (out_q.slot == mspc_pkg::SLOT_W'(mspc_pkg::SLOTS_PER_CHANNEL))))
    else $error("compare result fields inconsistent");

endmodule

### hw/rtl/mspc_ctrl.sv
// ----------------------------------------------------------------------------
// mspc_ctrl
// Sequencer: takes one request, steers decode, table read, engage copy
// sweep and result hand-off in the datapath.
// ----------------------------------------------------------------------------
module mspc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mspc_pkg::dp_status_t status_i,
  output mspc_pkg::ctrl_cmd_t  ctrl_o
);

  mspc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mspc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      mspc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.latch_in = 1'b1;
          state_d         = mspc_pkg::ST_DECODE;
        end
      end
      mspc_pkg::ST_DECODE: begin
        ctrl_o.decode = 1'b1;
        if (!status_i.is_cmp) begin
          if (!status_i.pkt_done) begin
            state_d = mspc_pkg::ST_IDLE;
          end else if (status_i.engage) begin
            state_d = mspc_pkg::ST_COPY;
          end else begin
            state_d = mspc_pkg::ST_EMIT;
          end
        end else if (!status_i.cmp_ok) begin
          state_d = mspc_pkg::ST_IDLE;
        end else if (status_i.slot_sync) begin
          state_d = mspc_pkg::ST_EMIT;
        end else begin
          state_d = mspc_pkg::ST_READ;
        end
      end
      mspc_pkg::ST_READ: begin
        ctrl_o.read_done = 1'b1;
        state_d          = mspc_pkg::ST_EMIT;
      end
      mspc_pkg::ST_COPY: begin
        ctrl_o.copy_step = 1'b1;
        if (status_i.copy_last) begin
          state_d = mspc_pkg::ST_EMIT;
        end
      end
      mspc_pkg::ST_EMIT: begin
        // wait until the output register can take the result
        if (status_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          state_d         = mspc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mspc_pkg::ST_IDLE;
      end
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mspc_pkg::ST_COPY && status_i.copy_last) |=> state_q == mspc_pkg::ST_EMIT)
    else $error("copy sweep did not end in result hand-off");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mspc_pkg::ST_DECODE && status_i.is_cmp && !status_i.cmp_ok)
    |=> state_q == mspc_pkg::ST_IDLE)
    else $error("compare on unused channel was not dropped");

endmodule

### dv/servo_pulse_check.sv
// ----------------------------------------------------------------------------
// servo_pulse_check
// Watches the request and result channels of the servo pulse controller,
// keeps its own copy of parser, tables and slot counters, and compares every
// returned packet ack or pulse interval with the one it works out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module servo_pulse_check (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mspc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mspc_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic                           cmd_i,
  input  logic [mspc_pkg::BYTE_W-1:0]    rx_byte_i,
  input  logic [mspc_pkg::CH_W-1:0]      channel_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic                           result_kind_i,
  input  logic [mspc_pkg::CH_W-1:0]      out_channel_i,
  input  logic [mspc_pkg::SLOT_W-1:0]    slot_i,
  input  logic [mspc_pkg::IVL_W-1:0]     interval_i,
  input  logic                           reset_pulse_i,
  input  logic [1:0]                     action_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             packets_o,
  output int                             intervals_o,
  output int                             syncs_o
);
  import mspc_pkg::*;

  logic [VAL_W-1:0]      max_command;
  logic [VAL_W-1:0]      pulse_offset;
  logic [IVL_W-1:0]      sync_gap;
  logic [ADDR_LOW_W-1:0] last_address;

  parse_phase_e          phase;
  logic [BYTE_W-1:0]     held_addr;
  logic [BYTE_W-1:0]     held_hi;
  logic [IVL_W-1:0]      position [NUM_SERVOS];
  logic [IVL_W-1:0]      staging [NUM_SERVOS];
  logic [SLOT_W-1:0]     next_slot [NUM_CHANNELS];

  result_t due_results [$];

  function automatic result_t pack_result(input kind_e k, input logic [CH_W-1:0] ch,
                                          input logic [SLOT_W-1:0] s,
                                          input logic [IVL_W-1:0] ivl, input logic rp,
                                          input action_e act);
    result_t r;
    r.kind        = k;
    r.channel     = ch;
    r.slot        = s;
    r.interval    = ivl;
    r.reset_pulse = rp;
    r.action      = act;
    return r;
  endfunction

  task automatic take_byte(input logic [BYTE_W-1:0] b);
    logic [VAL_W-1:0] value;
    logic [IVL_W-1:0] stored;
    logic [IVL_W-1:0] shown;
    action_e          act;
    case (phase)
      PH_SYNC: begin
        if (b == SYNC_BYTE) phase = PH_ADDR;
      end
      PH_ADDR: begin
        held_addr = b;
        if (b[ADDR_LOW_W-1:0] <= last_address || b == ENGAGE_ADDR) phase = PH_HIGH;
        else phase = PH_SKIP1;
      end
      PH_HIGH: begin
        held_hi = b;
        phase   = PH_LOW;
      end
      PH_LOW: begin
        phase = PH_SYNC;
        value = {held_hi, b};
        if (value > max_command) value = max_command;
        stored = IVL_W'(value) + IVL_W'(pulse_offset);
        act    = ACT_NONE;
        shown  = '0;
        if (held_addr < TABLE_LIMIT) begin
          position[held_addr[IDX_W-1:0]] = stored;
          act   = ACT_MOVE;
          shown = stored;
        end else if (held_addr < CACHE_LIMIT) begin
          staging[held_addr[IDX_W-1:0]] = stored;
          act   = ACT_CACHED;
          shown = stored;
        end else if (held_addr == ENGAGE_ADDR) begin
          position = staging;
          act      = ACT_ENGAGE;
        end
        due_results.push_back(pack_result(KIND_PACKET, '0, '0, shown, 1'b0, act));
      end
      PH_SKIP1: phase = PH_SKIP2;
      default:  phase = PH_SYNC;
    endcase
  endtask

  task automatic take_compare(input logic [CH_W-1:0] ch);
    logic [SLOT_W-1:0] s;
    logic [IVL_W-1:0]  ivl;
    logic              rp;
    int                idx;
    // compare on the unused channel leaves everything as it was
    if (ch < NUM_CHANNELS) begin
      s  = next_slot[ch];
      rp = 1'b0;
      if (s >= SLOTS_PER_CHANNEL) begin
        s             = SLOT_W'(SLOTS_PER_CHANNEL);
        ivl           = sync_gap;
        rp            = 1'b1;
        next_slot[ch] = '0;
      end else begin
        idx           = ch * SLOTS_PER_CHANNEL + s;
        ivl           = (idx < NUM_SERVOS) ? position[idx] : '0;
        next_slot[ch] = s + 1'b1;
      end
      due_results.push_back(pack_result(KIND_COMPARE, ch, s, ivl, rp, ACT_NONE));
    end
  endtask

  task automatic check_field(input string name, input logic [IVL_W-1:0] want,
                             input logic [IVL_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  task automatic check_result();
    result_t want;
    if (due_results.size() == 0) begin
      $error("unexpected result: kind %0d channel %0d slot %0d interval %0d action %0d",
             result_kind_i, out_channel_i, slot_i, interval_i, action_i);
      fail_count_o++;
    end else begin
      want = due_results.pop_front();
      check_field("result_kind", IVL_W'(want.kind), IVL_W'(result_kind_i));
      check_field("out_channel", IVL_W'(want.channel), IVL_W'(out_channel_i));
      check_field("slot", IVL_W'(want.slot), IVL_W'(slot_i));
      check_field("interval", want.interval, interval_i);
      check_field("reset_pulse", IVL_W'(want.reset_pulse), IVL_W'(reset_pulse_i));
      check_field("action", IVL_W'(want.action), IVL_W'(action_i));
      if (want.kind == KIND_PACKET) packets_o++;
      else intervals_o++;
      if (want.reset_pulse) syncs_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_command  = MAX_CMD_RST;
      pulse_offset = OFFSET_RST;
      sync_gap     = SYNC_GAP_RST;
      last_address = LAST_ADDR_RST;
      phase        = PH_SYNC;
      held_addr    = '0;
      held_hi      = '0;
      foreach (position[i]) begin
        position[i] = DEFAULT_POSITION;
        staging[i]  = DEFAULT_POSITION;
      end
      foreach (next_slot[i]) next_slot[i] = '0;
      due_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_MAX_COMMAND:  max_command  = cfg_data_i[VAL_W-1:0];
          CFG_PULSE_OFFSET: pulse_offset = cfg_data_i[VAL_W-1:0];
          CFG_SYNC_GAP:     sync_gap     = cfg_data_i[IVL_W-1:0];
          CFG_LAST_ADDRESS: last_address = cfg_data_i[ADDR_LOW_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) begin
        if (cmd_i) take_compare(channel_i);
        else take_byte(rx_byte_i);
      end
    end
    pending_o = due_results.size();
  end

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives serial packets and compare events into the servo pulse controller
// under changing register settings and flow-control mixes; the checker
// instance predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import mspc_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 6;
  localparam int SEGMENTS      = 6;
  localparam int SEGMENT_ITEMS = 240;
  localparam int HOLD_CYCLES   = 250;
  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 40;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              cfg_we      = 1'b0;
  cfg_reg_e          cfg_idx     = CFG_MAX_COMMAND;
  logic [CFG_W-1:0]  cfg_data    = '0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic              cmd         = 1'b0;
  logic [BYTE_W-1:0] rx_byte     = '0;
  logic [CH_W-1:0]   channel     = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic              result_kind;
  logic [CH_W-1:0]   out_channel;
  logic [SLOT_W-1:0] slot;
  logic [IVL_W-1:0]  interval;
  logic              reset_pulse;
  logic [1:0]        action;

  int send_idle_pct = 9;
  int recv_idle_pct = 82;
  logic hold_req    = 1'b0;
  int item_count    = 0;
  int stall_cycles  = 0;
  logic [VAL_W-1:0]      cur_max  = MAX_CMD_RST;
  logic [ADDR_LOW_W-1:0] cur_last = LAST_ADDR_RST;

  int fail_count;
  int pending;
  int packets;
  int intervals;
  int syncs;

  always #HALF_PERIOD clk = ~clk;

  multiplexed_servo_pulse_controller dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .cmd_i        (cmd),
    .rx_byte_i    (rx_byte),
    .channel_i    (channel),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .result_kind_o(result_kind),
    .out_channel_o(out_channel),
    .slot_o       (slot),
    .interval_o   (interval),
    .reset_pulse_o(reset_pulse),
    .action_o     (action)
  );

  servo_pulse_check u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .cmd_i        (cmd),
    .rx_byte_i    (rx_byte),
    .channel_i    (channel),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .result_kind_i(result_kind),
    .out_channel_i(out_channel),
    .slot_i       (slot),
    .interval_i   (interval),
    .reset_pulse_i(reset_pulse),
    .action_i     (action),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .packets_o    (packets),
    .intervals_o  (intervals),
    .syncs_o      (syncs)
  );

  // result side: random back-pressure, plus one long hold on request
  initial begin : receiver
    int hold_left;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // one request; returns right after the accepting edge with valid still high
  task automatic offer(input logic c, input logic [BYTE_W-1:0] b,
                       input logic [CH_W-1:0] ch);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    rx_byte  <= b;
    channel  <= ch;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    offer(1'b0, b, CH_W'($urandom));
  endtask

  task automatic send_compare(input logic [CH_W-1:0] ch);
    offer(1'b1, BYTE_W'($urandom), ch);
  endtask

  task automatic send_packet(input logic [BYTE_W-1:0] addr, input logic [VAL_W-1:0] value,
                             input bit mixed);
    logic [BYTE_W-1:0] seq [4];
    seq = '{SYNC_BYTE, addr, value[15:8], value[7:0]};
    foreach (seq[i]) begin
      // compare events may land in the middle of a packet
      if (mixed && $urandom_range(9) == 0) begin
        send_compare(CH_W'($urandom_range(NUM_CHANNELS - 1)));
        item_count++;
      end
      send_byte(seq[i]);
    end
    item_count += 4;
  endtask

  task automatic quiet_and_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    // byte requests without a result may still be in flight
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(input cfg_reg_e idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MAX_COMMAND) cur_max = data[VAL_W-1:0];
    if (idx == CFG_LAST_ADDRESS) cur_last = data[ADDR_LOW_W-1:0];
  endtask

  function automatic logic [BYTE_W-1:0] pick_address();
    logic [ADDR_LOW_W-1:0] low;
    int                    pick;
    low  = ADDR_LOW_W'($urandom_range(cur_last));
    pick = $urandom_range(99);
    if (pick < 40) return {3'd0, low};
    if (pick < 70) return {3'd1, low};
    if (pick < 78) return ENGAGE_ADDR;
    if (pick < 88) return {3'($urandom_range(7, 2)), low};
    return BYTE_W'($urandom);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return '1;
    if (pick < 20) return '0;
    if (pick < 30) return cur_max + VAL_W'($urandom_range(2)) - VAL_W'(1);
    return VAL_W'($urandom);
  endfunction

  task automatic random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      send_packet(pick_address(), pick_value(), 1'b1);
    end else if (pick < 85) begin
      send_compare(CH_W'($urandom_range(NUM_CHANNELS - 1)));
      item_count++;
    end else if (pick < 89) begin
      send_compare(CH_W'(NUM_CHANNELS));
      item_count++;
    end else if (pick < 95) begin
      send_byte(BYTE_W'($urandom));
      item_count++;
    end else begin
      // truncated packet, the parser has to find its way back
      send_byte(SYNC_BYTE);
      send_byte(pick_address());
      item_count += 2;
      if ($urandom_range(1)) begin
        send_byte(BYTE_W'($urandom));
        item_count++;
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] setting [4];
    int               target;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // directed: noise, clamp, cache write, rejected address, no-effect address,
    // engage, compares on live and unused channels
    send_byte(8'h00);
    send_packet(8'd0, 16'hFFFF, 1'b0);
    send_packet(8'd55, 16'h0000, 1'b0);
    send_packet(8'd24, 16'hFFFF, 1'b0);
    send_packet(8'd100, 16'h1234, 1'b0);
    send_packet(ENGAGE_ADDR, 16'h0BAD, 1'b0);
    send_compare(CH_W'(0));
    send_compare(CH_W'(NUM_CHANNELS - 1));
    send_compare(CH_W'(NUM_CHANNELS));

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: setting = '{17'h0FFFF, 17'h0FFFF, 17'h1FFFF, 17'd31};
        1: setting = '{default: '0};
        2: setting = '{CFG_W'($urandom_range(65535)), CFG_W'($urandom_range(65535)),
                       CFG_W'($urandom), CFG_W'($urandom_range(31))};
        4: setting = '{CFG_W'(MAX_CMD_RST), CFG_W'(OFFSET_RST),
                       CFG_W'(SYNC_GAP_RST), CFG_W'(LAST_ADDR_RST)};
        default: setting = '{CFG_W'($urandom), CFG_W'($urandom),
                             CFG_W'($urandom), CFG_W'($urandom)};
      endcase
      quiet_and_drain();
      foreach (setting[i]) write_cfg(cfg_reg_e'(i), setting[i]);
      send_idle_pct = (seg < 2) ? 9 : (seg < 4) ? 82 : 0;
      recv_idle_pct = (seg < 2) ? 82 : (seg < 4) ? 9 : 0;
      // long result stall while requests keep coming
      if (seg == 4) hold_req = 1'b1;
      target = item_count + SEGMENT_ITEMS;
      while (item_count < target) random_item();
    end

    quiet_and_drain();
    $display("run drove %0d requests through %0d register settings and three stall mixes",
             item_count, SEGMENTS + 1);
    $display("checked %0d packet acks and %0d pulse intervals, %0d of them sync slots",
             packets, intervals, syncs);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/mspc_pkg.sv
hw/rtl/mspc_datapath.sv
hw/rtl/mspc_ctrl.sv
hw/rtl/multiplexed_servo_pulse_controller.sv
dv/servo_pulse_check.sv
dv/tb.sv
